@@ rtl/sppa_pkg.sv @@
// Shared types and constants for the send page pool allocator.
// No dependencies; imported by every module of the block but sppa_ram.
`timescale 1ns / 1ps

package sppa_pkg;

    // Defaults for the top-level parameters
    localparam int PAGES_DEF        = 4;
    localparam int HEADER_BYTES_DEF = 16;

    // Field widths
    localparam int FILL_W = 21;
    localparam int MSGS_W = 16;
    localparam int TIME_W = 32;
    localparam int TMO_W  = 8;
    localparam int NEED_W = FILL_W + 1;

    localparam logic [FILL_W-1:0] CAP_RESET = 21'd65536;
    localparam logic [TMO_W-1:0]  TMO_RESET = 8'd1;
    localparam logic [MSGS_W-1:0] MSGS_MAX  = 16'hFFFF;

    // Register index, taken from paddr[2]
    localparam logic REG_CAP = 1'b0;
    localparam logic REG_TMO = 1'b1;

    // Request codes
    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_SWITCH = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic              sending;
        logic [FILL_W-1:0] fill;
        logic [MSGS_W-1:0] msgs;
        logic [TIME_W-1:0] last_send;
    } page_rec_t;

    typedef struct packed {
        logic              status;
        logic [1:0]        page_index;
        logic [FILL_W-1:0] byte_offset;
        logic [MSGS_W-1:0] message_count;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } ctrl_state_t;

endpackage

@@ rtl/send_page_pool_allocator_top.sv @@
// Top level of the send page pool allocator: APB registers, page store
// and request sequencer. Depends on sppa_pkg, sppa_page_store, sppa_ctrl.
`timescale 1ns / 1ps

// Channel      Signals                                          Direction
// ----------   ----------------------------------------------   ---------
// request      start/busy, req_type, start_page, msg_length,     in
//              now_seconds
// result       result_valid, status, page_index, byte_offset,    out
//              message_count
// config       psel, penable, pwrite, paddr, pwdata, prdata,     APB
//              pready
//
// A request transaction is taken when start is high and busy is low. The
// page records sit in one RAM (registered read); the sequencer reads one page
// per cycle and evaluates it the cycle after, so the RAM read port sets the
// pace. A push stops on the first page scanned that has room for it and fails
// if none has; a switch always walks every page. result_valid pulses for one
// cycle; busy drops on the same edge, so the next request may be taken while
// the result is shown. The receiver cannot stall. Reset is asynchronous,
// active low; per-page valid bits clear the pool at once, no clearing pass
// is needed. Each page is visited once per transaction, so a write-back
// never meets a read of the same page.

module send_page_pool_allocator_top
    import sppa_pkg::*;
#(
    parameter int PAGES        = PAGES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [1:0]        start_page,
    input  logic [FILL_W-1:0] msg_length,
    input  logic [TIME_W-1:0] now_seconds,
    // result
    output logic              result_valid,
    output logic              status,
    output logic [1:0]        page_index,
    output logic [FILL_W-1:0] byte_offset,
    output logic [MSGS_W-1:0] message_count,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [FILL_W-1:0] cap_reg, cap_next;
    logic [TMO_W-1:0]  tmo_reg, tmo_next;
    logic              cfg_wr;

    logic [IDX_W-1:0]  rd_addr;
    page_rec_t         rd_rec;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    page_rec_t         wr_rec;
    result_t           res;

    // Configuration registers; paddr[2] selects the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cap_next = cap_reg;
        tmo_next = tmo_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CAP: cap_next = pwdata[FILL_W-1:0];
                REG_TMO: tmo_next = pwdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CAP: prdata = 32'(cap_reg);
            REG_TMO: prdata = 32'(tmo_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            tmo_reg <= TMO_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
            tmo_reg <= tmo_next;
        end
    end

    sppa_page_store #(
        .PAGES (PAGES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_rec  (wr_rec)
    );

    sppa_ctrl #(
        .PAGES        (PAGES),
        .HEADER_BYTES (HEADER_BYTES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .start_page  (start_page),
        .msg_length  (msg_length),
        .now_seconds (now_seconds),
        .cap         (cap_reg),
        .timeout     (tmo_reg),
        .busy        (busy),
        .rd_addr     (rd_addr),
        .rd_rec      (rd_rec),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_rec      (wr_rec),
        .res_valid   (result_valid),
        .res         (res)
    );

    assign status        = res.status;
    assign page_index    = res.page_index;
    assign byte_offset   = res.byte_offset;
    assign message_count = res.message_count;

`ifndef SYNTHESIS
    // A result only ends a transaction that was in progress.
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a transaction in progress");

    // The sequencer goes idle exactly when it delivers a result.
    a_idle_with_res: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("transaction ended without a result");

    // One result per transaction: never two strobes back to back.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // A failed transaction reports zero fields.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_FAIL) |->
            (page_index == '0 && byte_offset == '0 && message_count == '0))
        else $error("failure result with nonzero fields");
`endif

endmodule

@@ rtl/sppa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/sppa_page_store.sv @@
// Page record store: RAM plus per-page valid bits that stand in for reset.
// Depends on sppa_pkg and sppa_ram.
`timescale 1ns / 1ps

module sppa_page_store
    import sppa_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    parameter int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    output page_rec_t        rd_rec,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  page_rec_t        wr_rec
);

    logic [$bits(page_rec_t)-1:0] ram_q;
    logic [PAGES-1:0]             valid_reg;
    logic                         rd_vld_reg;

    sppa_ram #(
        .WIDTH ($bits(page_rec_t)),
        .DEPTH (PAGES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_rec),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // A page never written reads as the all-zero reset record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_rec = rd_vld_reg ? page_rec_t'(ram_q) : '0;

endmodule

@@ rtl/sppa_ctrl.sv @@
// Request sequencer: walks page records through the store, one read per
// cycle, evaluates push/switch and writes back. Depends on sppa_pkg.
`timescale 1ns / 1ps

module sppa_ctrl
    import sppa_pkg::*;
#(
    parameter int PAGES        = PAGES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int IDX_W        = (PAGES > 1) ? $clog2(PAGES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  logic [1:0]        start_page,
    input  logic [FILL_W-1:0] msg_length,
    input  logic [TIME_W-1:0] now_seconds,
    input  logic [FILL_W-1:0] cap,
    input  logic [TMO_W-1:0]  timeout,
    output logic              busy,
    output logic [IDX_W-1:0]  rd_addr,
    input  page_rec_t         rd_rec,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output page_rec_t         wr_rec,
    output logic              res_valid,
    output result_t           res
);

    localparam int CNT_W = $clog2(PAGES + 1);

    ctrl_state_t state_reg, state_next;

    logic              req_reg, req_next;
    logic [FILL_W-1:0] len_reg, len_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic              ev_last_reg, ev_last_next;
    logic              found_reg, found_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              issue;
    logic              done;
    logic              match;
    logic [4:0]        start_mod;
    logic [NEED_W-1:0] need;
    logic [FILL_W-1:0] room;
    logic              fit;
    logic              half;
    logic              aged;
    logic [TIME_W-1:0] age;
    result_t           hit_res;
    result_t           fail_res;

    assign accept = start && (state_reg == ST_IDLE);

    // start_page modulo PAGES by repeated subtract (at most three steps)
    always_comb
    begin
        start_mod = 5'(start_page);
        for (int k = 0; k < 3; k++)
        begin
            if (start_mod >= 5'(PAGES))
            begin
                start_mod = start_mod - 5'(PAGES);
            end
        end
    end

    // Page evaluation on the record just read
    assign need = NEED_W'(HEADER_BYTES) + {1'b0, len_reg};
    assign room = (rd_rec.fill <= cap) ? (cap - rd_rec.fill) : '0;
    assign fit  = !rd_rec.sending && ({1'b0, room} >= need);
    assign half = rd_rec.fill > (cap >> 1);
    assign age  = now_reg - rd_rec.last_send;
    assign aged = (age >= TIME_W'(timeout)) && (rd_rec.fill != '0);

    assign fail_res = '{status: STATUS_FAIL, page_index: '0, byte_offset: '0,
                        message_count: '0};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_rec  = rd_rec;
        done    = 1'b0;
        match   = 1'b0;
        hit_res = fail_res;
        if (ev_vld_reg)
        begin
            if (req_reg == REQ_PUSH)
            begin
                if (fit)
                begin
                    wr_en       = 1'b1;
                    wr_rec.fill = FILL_W'({1'b0, rd_rec.fill} + need);
                    if (rd_rec.msgs != MSGS_MAX)
                    begin
                        wr_rec.msgs = rd_rec.msgs + MSGS_W'(1);
                    end
                    done    = 1'b1;
                    match   = 1'b1;
                    hit_res = '{status: STATUS_OK, page_index: 2'(ev_idx_reg),
                                byte_offset: rd_rec.fill,
                                message_count: wr_rec.msgs};
                end
                else if (ev_last_reg)
                begin
                    done = 1'b1;
                end
            end
            else
            begin
                if (rd_rec.sending)
                begin
                    // recycle: writable, empty, stamped with now
                    wr_en  = 1'b1;
                    wr_rec = '{sending: 1'b0, fill: '0, msgs: '0,
                               last_send: now_reg};
                end
                else if ((half || aged) && !found_reg)
                begin
                    wr_en          = 1'b1;
                    wr_rec.sending = 1'b1;
                    match          = 1'b1;
                    hit_res = '{status: STATUS_OK, page_index: 2'(ev_idx_reg),
                                byte_offset: rd_rec.fill,
                                message_count: rd_rec.msgs};
                end
                done = ev_last_reg;
            end
        end
    end

    assign wr_addr = ev_idx_reg;
    assign rd_addr = rd_idx_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control
    always_comb
    begin
        busy  = (state_reg == ST_SCAN);
        issue = (state_reg == ST_SCAN) && (rd_cnt_reg != CNT_W'(PAGES)) && !done;
    end

    always_comb
    begin
        req_next       = req_reg;
        len_next       = len_reg;
        now_next       = now_reg;
        rd_idx_next    = rd_idx_reg;
        rd_cnt_next    = rd_cnt_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        ev_vld_next    = issue;
        ev_idx_next    = rd_idx_reg;
        ev_last_next   = (rd_cnt_reg == CNT_W'(PAGES - 1));
        res_valid_next = done;

        if (accept)
        begin
            req_next    = req_type;
            len_next    = msg_length;
            now_next    = now_seconds;
            rd_idx_next = (req_type == REQ_PUSH) ? IDX_W'(start_mod) : '0;
            rd_cnt_next = '0;
            found_next  = 1'b0;
        end
        else if (issue)
        begin
            rd_idx_next = (rd_idx_reg == IDX_W'(PAGES - 1)) ? '0
                                                            : rd_idx_reg + IDX_W'(1);
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end

        if (match)
        begin
            found_next = 1'b1;
            res_next   = hit_res;
        end
        else if (done && !found_reg)
        begin
            res_next = fail_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            ev_last_reg   <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            ev_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            ev_vld_reg    <= ev_vld_next;
            ev_last_reg   <= ev_last_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            rd_idx_reg    <= rd_idx_next;
            ev_idx_reg    <= ev_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        len_reg <= len_next;
        now_reg <= now_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
